// ===== design/sgbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sgbe_pkg
// Types and constants for the stillness gated gyro bias estimator: sample and
// result request payloads, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sgbe_pkg;

  localparam int unsigned WINDOW_DEFAULT = 50;

  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned THRESH_W = 34;

  localparam logic [THRESH_W-1:0] THRESH_RST = 34'd16777;
  localparam logic [15:0]         WARMUP_RST = 16'd100;
  localparam logic [7:0]          TARGET_RST = 8'd50;
  localparam logic [7:0]          RELOAD_RST = 8'd40;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_WARMUP = 2'd1,
    REG_TARGET = 2'd2,
    REG_RELOAD = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        sample_count;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_y;
    logic signed [15:0] bias_z;
    logic               bias_updated;
    logic               is_still;
  } result_t;

endpackage

`default_nettype wire

// ===== design/stillness_gyro_bias_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// stillness_gyro_bias_estimator_unit
// Windowed accel variance test gating a gyro bias update from the window mean.
// ----------------------------------------------------------------------------
// Takes one sample request per clock unless the output stalls, and returns
// one result request per sample. The rate is set by the sample ring: one
// memory of WINDOW entries with one write and one registered read per
// accepted sample, the read prefetching the entry the next sample replaces.
// Running sums take one add per sample. Variance products with the reciprocal
// multiply of the window mean division, the variance difference with the
// division's one correction, and the stillness compare each fill a stage. The
// ring needs no clearing pass after reset: entries not yet written read as
// zero through a fill flag. The user must write registers over APB only while
// the block holds no requests in flight; the block does not enforce this.
`default_nettype none

module stillness_gyro_bias_estimator_unit
  import sgbe_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sample_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned K    = $clog2(WINDOW);
  localparam int unsigned PTRW = (K < 1) ? 1 : K;
  localparam int unsigned AW   = 16 + K;
  localparam int unsigned SQW  = 31 + K;
  localparam int unsigned PW   = 32 + 2 * K;
  localparam int unsigned TOTW = PW + 2;
  localparam int unsigned GW   = 16 + K;
  localparam logic [GW-1:0]   RCP     = GW'((longint'(1) << GW) / longint'(WINDOW));
  localparam logic [TOTW-1:0] LIM_RST = TOTW'(THRESH_RST) * TOTW'(WINDOW * WINDOW);

  // handshake
  logic en, accept;

  // configuration
  logic [THRESH_W-1:0] thr_q;
  logic [15:0]         warm_q;
  logic [7:0]          target_q, reload_q;
  logic [TOTW-1:0]     lim_q;
  logic                cfg_wr;

  // ring
  logic [95:0]     ring_mem [WINDOW];
  logic [95:0]     ring_rd_q;
  logic [95:0]     ring_wr;
  logic [PTRW-1:0] ptr_q, ptr_nxt;
  logic            wrapped_q;

  logic signed [15:0] in_acc [3];
  logic signed [15:0] in_gyr [3];
  logic signed [15:0] old_acc [3];
  logic signed [15:0] old_gyr [3];

  // stage 1: accepted sample and the entry it replaces
  logic               st1_valid_q;
  logic [15:0]        st1_cnt_q;
  logic signed [15:0] st1_acc_q [3];
  logic signed [15:0] st1_gyr_q [3];
  logic signed [15:0] st1_oacc_q [3];
  logic signed [15:0] st1_ogyr_q [3];
  logic signed [31:0] new_sq [3];
  logic signed [31:0] old_sq [3];

  // stage 2: deltas to the running sums
  logic               st2_valid_q;
  logic [15:0]        st2_cnt_q;
  logic signed [16:0] st2_acc_dlt_q [3];
  logic signed [31:0] st2_sq_dlt_q [3];
  logic signed [16:0] st2_gyr_dlt_q [3];

  // running sums
  logic signed [AW-1:0] acc_sum_q [3];
  logic [SQW-1:0]       sq_sum_q [3];
  logic signed [GW-1:0] gyr_sum_q [3];

  // stage 3: sums are current for this sample
  logic                 st3_valid_q;
  logic [15:0]          st3_cnt_q;
  logic signed [PW-1:0] acc_wide [3];
  logic [PW-1:0]        sq1_d [3];
  logic [PW-1:0]        ws2_d [3];
  logic [GW-1:0]        gmag_d [3];
  logic [2*GW-1:0]      gprod [3];

  // stage 4: products
  logic          st4_valid_q;
  logic [15:0]   st4_cnt_q;
  logic [PW-1:0] st4_sq1_q [3];
  logic [PW-1:0] st4_ws2_q [3];
  logic [GW-1:0] st4_gmag_q [3];
  logic          st4_gneg_q [3];
  logic [16:0]   st4_gq0_q [3];
  logic signed [PW:0] dvar [3];
  logic [PW-1:0]      dvar_cl [3];
  logic [GW:0]        gqw [3];
  logic [GW:0]        grem [3];
  logic [16:0]        gq [3];
  logic [2:0][15:0]   mean_d;

  // stage 5: per axis variance terms and window mean
  logic             st5_valid_q;
  logic [15:0]      st5_cnt_q;
  logic [PW-1:0]    st5_d_q [3];
  logic [2:0][15:0] st5_mean_q;

  // decision and output
  logic [TOTW-1:0]  total;
  logic [7:0]       cnt_q, cnt_d, cnt_inc;
  logic [2:0][15:0] bias_q, bias_d;
  logic             upd, still;
  logic             out_valid_q;
  result_t          out_q, out_d;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign accept      = in_valid_i && en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (cfg_reg_e'(paddr[CFG_AW-1:3]))
      REG_THRESH: prdata = CFG_DW'(thr_q);
      REG_WARMUP: prdata = CFG_DW'(warm_q);
      REG_TARGET: prdata = CFG_DW'(target_q);
      REG_RELOAD: prdata = CFG_DW'(reload_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THRESH_RST;
      warm_q   <= WARMUP_RST;
      target_q <= TARGET_RST;
      reload_q <= RELOAD_RST;
      lim_q    <= LIM_RST;
    end else begin
      lim_q <= TOTW'(thr_q) * TOTW'(WINDOW * WINDOW);
      if (cfg_wr) begin
        case (cfg_reg_e'(paddr[CFG_AW-1:3]))
          REG_THRESH: thr_q    <= pwdata[THRESH_W-1:0];
          REG_WARMUP: warm_q   <= pwdata[15:0];
          REG_TARGET: target_q <= pwdata[7:0];
          REG_RELOAD: reload_q <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- ring
  assign ptr_nxt = (ptr_q == PTRW'(WINDOW - 1)) ? '0 : ptr_q + PTRW'(1);
  assign ring_wr = {in_data_i.gyro_z, in_data_i.gyro_y, in_data_i.gyro_x,
                    in_data_i.accel_z, in_data_i.accel_y, in_data_i.accel_x};

  always_comb begin
    in_acc[0] = in_data_i.accel_x;
    in_acc[1] = in_data_i.accel_y;
    in_acc[2] = in_data_i.accel_z;
    in_gyr[0] = in_data_i.gyro_x;
    in_gyr[1] = in_data_i.gyro_y;
    in_gyr[2] = in_data_i.gyro_z;
    for (int a = 0; a < 3; a++) begin
      old_acc[a] = wrapped_q ? ring_rd_q[16*a +: 16] : '0;
      old_gyr[a] = wrapped_q ? ring_rd_q[48 + 16*a +: 16] : '0;
    end
  end

  // prefetch of the entry the next sample overwrites
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[ptr_q] <= ring_wr;
      ring_rd_q       <= ring_mem[ptr_nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
    end else if (accept) begin
      ptr_q <= ptr_nxt;
      if (ptr_q == PTRW'(WINDOW - 1)) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
      st2_valid_q <= 1'b0;
      st3_valid_q <= 1'b0;
      st4_valid_q <= 1'b0;
      st5_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      st1_valid_q <= in_valid_i;
      st2_valid_q <= st1_valid_q;
      st3_valid_q <= st2_valid_q;
      st4_valid_q <= st3_valid_q;
      st5_valid_q <= st4_valid_q;
      out_valid_q <= st5_valid_q;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      new_sq[a] = 32'(st1_acc_q[a]) * 32'(st1_acc_q[a]);
      old_sq[a] = 32'(st1_oacc_q[a]) * 32'(st1_oacc_q[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_wide[a] = PW'(acc_sum_q[a]);
      sq1_d[a]    = acc_wide[a] * acc_wide[a];
      ws2_d[a]    = PW'(sq_sum_q[a]) * PW'(WINDOW);
      gmag_d[a]   = gyr_sum_q[a][GW-1] ? GW'(-gyr_sum_q[a]) : GW'(gyr_sum_q[a]);
      gprod[a]    = (2*GW)'(gmag_d[a]) * (2*GW)'(RCP);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dvar[a]    = $signed({1'b0, st4_ws2_q[a]}) - $signed({1'b0, st4_sq1_q[a]});
      dvar_cl[a] = dvar[a][PW] ? '0 : dvar[a][PW-1:0];
      gqw[a]     = (GW+1)'(st4_gq0_q[a]) * (GW+1)'(WINDOW);
      grem[a]    = (GW+1)'(st4_gmag_q[a]) - gqw[a];
      gq[a]      = (grem[a] >= (GW+1)'(WINDOW)) ? st4_gq0_q[a] + 17'd1 : st4_gq0_q[a];
      mean_d[a]  = st4_gneg_q[a] ? 16'(17'd0 - gq[a]) : gq[a][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_cnt_q <= in_data_i.sample_count;
      st2_cnt_q <= st1_cnt_q;
      st3_cnt_q <= st2_cnt_q;
      st4_cnt_q <= st3_cnt_q;
      st5_cnt_q <= st4_cnt_q;
      st5_mean_q <= mean_d;
      out_q      <= out_d;
      for (int a = 0; a < 3; a++) begin
        st1_acc_q[a]     <= in_acc[a];
        st1_gyr_q[a]     <= in_gyr[a];
        st1_oacc_q[a]    <= old_acc[a];
        st1_ogyr_q[a]    <= old_gyr[a];
        st2_acc_dlt_q[a] <= 17'(st1_acc_q[a]) - 17'(st1_oacc_q[a]);
        st2_sq_dlt_q[a]  <= new_sq[a] - old_sq[a];
        st2_gyr_dlt_q[a] <= 17'(st1_gyr_q[a]) - 17'(st1_ogyr_q[a]);
        st4_sq1_q[a]     <= sq1_d[a];
        st4_ws2_q[a]     <= ws2_d[a];
        st4_gmag_q[a]    <= gmag_d[a];
        st4_gneg_q[a]    <= gyr_sum_q[a][GW-1];
        st4_gq0_q[a]     <= gprod[a][GW +: 17];
        st5_d_q[a]       <= dvar_cl[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        acc_sum_q[a] <= '0;
        sq_sum_q[a]  <= '0;
        gyr_sum_q[a] <= '0;
      end
    end else if (en && st2_valid_q) begin
      for (int a = 0; a < 3; a++) begin
        acc_sum_q[a] <= acc_sum_q[a] + AW'(st2_acc_dlt_q[a]);
        sq_sum_q[a]  <= sq_sum_q[a] + SQW'(st2_sq_dlt_q[a]);
        gyr_sum_q[a] <= gyr_sum_q[a] + GW'(st2_gyr_dlt_q[a]);
      end
    end
  end

  // ---------------------------------------------------------------- decision
  assign total   = TOTW'(st5_d_q[0]) + TOTW'(st5_d_q[1]) + TOTW'(st5_d_q[2]);
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    cnt_d  = cnt_q;
    bias_d = bias_q;
    upd    = 1'b0;
    still  = 1'b0;
    if (st5_cnt_q > warm_q) begin
      if (total < lim_q) begin
        still = 1'b1;
        if (cnt_inc == target_q) begin
          upd    = 1'b1;
          cnt_d  = reload_q;
          bias_d = st5_mean_q;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        cnt_d = '0;
      end
    end
    out_d.bias_x       = bias_d[0];
    out_d.bias_y       = bias_d[1];
    out_d.bias_z       = bias_d[2];
    out_d.bias_updated = upd;
    out_d.is_still     = still;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bias_q <= '0;
    end else if (en && st5_valid_q) begin
      cnt_q  <= cnt_d;
      bias_q <= bias_d;
    end
  end

  // ---------------------------------------------------------------- checks
  a_upd_implies_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.bias_updated || out_data_o.is_still))
    else $error("bias update reported without stillness");

  a_reload_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && st5_valid_q && upd) |=> (cnt_q == $past(reload_q)))
    else $error("counter not reloaded after bias update");

  a_bias_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en && st5_valid_q && upd) |=> $stable(bias_q))
    else $error("bias changed without an update");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(ptr_q))
    else $error("ring pointer moved without an accepted sample");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTRW'(WINDOW - 1))
    else $error("ring pointer out of range");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stillness gated gyro bias estimator.
// ----------------------------------------------------------------------------
// Sample requests are driven on the input channel and every result request is
// compared field by field against a bit-accurate predictor of the window sums,
// variance test, still counter and bias update. Still runs of near-constant
// acceleration alternate with bursts of motion across several register
// settings. Handshake gaps on both channels are randomised, and a long output
// hold-off backs the pipeline up. Registers are read back after each write.
// ----------------------------------------------------------------------------
module tb
  import sgbe_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RING        = WINDOW_DEFAULT;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     HOLD_CYCLES = 300;

  class bias_scoreboard;
    shortint           accel_ring[WINDOW_DEFAULT][3];
    shortint           gyro_ring[WINDOW_DEFAULT][3];
    int unsigned       slot;
    longint            accel_sum[3];
    longint            accel_sq_sum[3];
    longint            gyro_sum[3];
    byte unsigned      still_run;
    shortint           bias[3];
    longint unsigned   var_thresh;
    shortint unsigned  warmup;
    byte unsigned      target;
    byte unsigned      reload;
    result_t           expected_bias_q[$];
    int                mismatches;

    function new();
      var_thresh = THRESH_RST;
      warmup     = WARMUP_RST;
      target     = TARGET_RST;
      reload     = RELOAD_RST;
    endfunction

    function void set_reg(cfg_reg_e r, longint unsigned v);
      case (r)
        REG_THRESH: var_thresh = v & ((64'd1 << THRESH_W) - 1);
        REG_WARMUP: warmup     = v[15:0];
        REG_TARGET: target     = v[7:0];
        REG_RELOAD: reload     = v[7:0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      longint          acc_new[3];
      longint          gyr_new[3];
      longint          d;
      longint unsigned total;
      longint unsigned lim;
      result_t         e;
      int              a;
      acc_new[0] = s.accel_x;
      acc_new[1] = s.accel_y;
      acc_new[2] = s.accel_z;
      gyr_new[0] = s.gyro_x;
      gyr_new[1] = s.gyro_y;
      gyr_new[2] = s.gyro_z;
      for (a = 0; a < 3; a++) begin
        accel_sum[a]    += acc_new[a] - accel_ring[slot][a];
        accel_sq_sum[a] += acc_new[a] * acc_new[a]
                           - longint'(accel_ring[slot][a]) * accel_ring[slot][a];
        gyro_sum[a]     += gyr_new[a] - gyro_ring[slot][a];
        accel_ring[slot][a] = shortint'(acc_new[a]);
        gyro_ring[slot][a]  = shortint'(gyr_new[a]);
      end
      slot = (slot + 1 >= WINDOW_DEFAULT) ? 0 : slot + 1;

      e.bias_updated = 1'b0;
      e.is_still     = 1'b0;
      if (s.sample_count > warmup) begin
        total = 0;
        lim   = var_thresh * unsigned'(RING * RING);
        for (a = 0; a < 3; a++) begin
          d = RING * accel_sq_sum[a] - accel_sum[a] * accel_sum[a];
          if (d > 0) total += unsigned'(d);
        end
        if (total < lim) begin
          e.is_still = 1'b1;
          still_run  = still_run + 8'd1;
          if (still_run == target) begin
            for (a = 0; a < 3; a++) bias[a] = shortint'(gyro_sum[a] / RING);
            still_run      = reload;
            e.bias_updated = 1'b1;
          end
        end else begin
          still_run = 8'd0;
        end
      end
      e.bias_x = bias[0];
      e.bias_y = bias[1];
      e.bias_z = bias[2];
      expected_bias_q.push_back(e);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_bias(result_t r);
      result_t e;
      if (expected_bias_q.size() == 0) begin
        mismatches++;
        $error("result request with no sample pending");
        return;
      end
      e = expected_bias_q.pop_front();
      compare("bias_x", e.bias_x, r.bias_x);
      compare("bias_y", e.bias_y, r.bias_y);
      compare("bias_z", e.bias_z, r.bias_z);
      compare("bias_updated", e.bias_updated, r.bias_updated);
      compare("is_still", e.is_still, r.is_still);
    endfunction

    function int pending();
      return expected_bias_q.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  sample_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  result_t           out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [CFG_AW-1:0] paddr       = '0;
  logic [CFG_DW-1:0] pwdata      = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  bias_scoreboard    sb = new();
  int                tx_pct;
  int                rx_pct;
  bit                hold_req;
  int                hold_left;
  int                cycle_no;
  int                cfg_errors;
  shortint unsigned  sample_no;

  stillness_gyro_bias_estimator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_no++;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_bias(out_data_o);
    end
  end

  // output side back-pressure, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  function longint unsigned reg_mask(cfg_reg_e r);
    case (r)
      REG_THRESH: return (64'd1 << THRESH_W) - 1;
      REG_WARMUP: return 64'hFFFF;
      default:    return 64'hFF;
    endcase
  endfunction

  task automatic cfg_read_check(cfg_reg_e r, longint unsigned want);
    logic [CFG_DW-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 3'b000};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      cfg_errors++;
      $error("%s readback: expected %0h, got %0h", r.name(), want, got);
    end
  endtask

  task automatic cfg_write(cfg_reg_e r, longint unsigned v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(r, v);
    cfg_read_check(r, v & reg_mask(r));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic configure(longint unsigned th, longint unsigned wu,
                           longint unsigned tg, longint unsigned rl);
    wait_drained();
    cfg_write(REG_THRESH, th);
    cfg_write(REG_WARMUP, wu);
    cfg_write(REG_TARGET, tg);
    cfg_write(REG_RELOAD, rl);
  endtask

  // called just after a falling edge; returns just after one
  task automatic offer_sample(sample_t s);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int gz,
                                 int cnt);
    sample_t s;
    s.accel_x      = 16'(ax);
    s.accel_y      = 16'(ay);
    s.accel_z      = 16'(az);
    s.gyro_x       = 16'(gx);
    s.gyro_y       = 16'(gy);
    s.gyro_z       = 16'(gz);
    s.sample_count = 16'(cnt);
    return s;
  endfunction

  function int jitter(int amp);
    return int'($urandom_range(2 * amp)) - amp;
  endfunction

  function shortint unsigned next_count();
    if ($urandom_range(19) == 0) return 16'($urandom);
    sample_no++;
    return sample_no;
  endfunction

  task automatic run_phase(int count, bit with_hold, bit with_pause);
    int      k;
    int      a;
    int      run_left;
    bit      calm;
    bit      wild_gyro;
    int      amp;
    int      gamp;
    int      ab[3];
    int      gb[3];
    sample_t s;
    run_left = 0;
    for (k = 0; k < count; k++) begin
      if (with_hold && k == 20) hold_req = 1'b1;
      if (with_pause && k == count / 2) wait_drained();
      if (run_left == 0) begin
        calm      = ($urandom_range(99) < 70);
        run_left  = calm ? $urandom_range(40, 160) : $urandom_range(1, 15);
        amp       = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        gamp      = $urandom_range(400);
        wild_gyro = ($urandom_range(4) == 0);
        for (a = 0; a < 3; a++) begin
          ab[a] = int'($urandom_range(60000)) - 30000;
          gb[a] = int'($urandom_range(64000)) - 32000;
        end
      end
      run_left--;
      s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
      // calm runs carry the odd motion glitch
      if (calm && $urandom_range(49) != 0) begin
        s.accel_x = 16'(ab[0] + jitter(amp));
        s.accel_y = 16'(ab[1] + jitter(amp));
        s.accel_z = 16'(ab[2] + jitter(amp));
        if (!wild_gyro) begin
          s.gyro_x = 16'(gb[0] + jitter(gamp));
          s.gyro_y = 16'(gb[1] + jitter(gamp));
          s.gyro_z = 16'(gb[2] + jitter(gamp));
        end
      end
      s.sample_count = next_count();
      offer_sample(s);
    end
  endtask

  initial begin
    int tg;
    int rl;
    tx_pct = 15;
    rx_pct = 46;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_read_check(REG_THRESH, THRESH_RST);
    cfg_read_check(REG_WARMUP, WARMUP_RST);
    cfg_read_check(REG_TARGET, TARGET_RST);
    cfg_read_check(REG_RELOAD, RELOAD_RST);

    // always still once past warm-up; upper write bits are dropped
    configure(64'h3_FFFF_FFFF, 64'hDEAD_BEEF_0000_0000, 3, 1);
    offer_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 0));
    offer_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 1));
    offer_sample(mk(0, 0, 0, 32767, -32768, -1, 65535));
    offer_sample(mk(32767, -32768, 0, -32768, 32767, 1, 2));
    offer_sample(mk(1, -1, 0, -1, 1, 0, 3));
    offer_sample(mk(0, 0, 0, -32768, -32768, -32768, 4));
    offer_sample(mk(-1, -1, -1, 32767, 32767, 32767, 5));
    offer_sample(mk(4096, 0, -4096, 12345, -12345, 99, 6));

    // warm-up never left, then a zero threshold that never passes
    configure(0, 64'hFFFF_FFFF_FFFF_FFFF, 255, 254);
    offer_sample(mk(100, 200, 300, 10, 20, 30, 65535));
    offer_sample(mk(-7, 8, -9, 1, 2, 3, 65534));
    configure(0, 0, 255, 254);
    offer_sample(mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1));
    offer_sample(mk(0, 0, 0, 0, 0, 0, 1));
    configure(64'hFFFF_FFFF_FFFF_FFFF, 0, 255, 254);
    offer_sample(mk(5, 5, 5, -5, -5, -5, 7));
    offer_sample(mk(5, 5, 5, -5, -5, -5, 8));
    offer_sample(mk(5, 5, 5, -5, -5, -5, 9));

    configure(16777, 10, 5, 2);
    run_phase(110, 1'b1, 1'b0);
    configure(200000, 40, 12, 0);
    run_phase(110, 1'b0, 1'b0);

    tx_pct = 46;
    rx_pct = 15;
    configure(64'h3_FFFF_FFFF, 0, 2, 200);
    run_phase(110, 1'b0, 1'b1);
    tg = $urandom_range(1, 20);
    rl = $urandom_range(0, tg - 1);
    configure({$urandom, $urandom}, $urandom_range(50), tg, rl);
    run_phase(110, 1'b0, 1'b0);

    tx_pct = 0;
    rx_pct = 0;
    configure(1, 0, 1, 0);
    run_phase(110, 1'b0, 1'b0);
    configure(THRESH_RST, WARMUP_RST, TARGET_RST, RELOAD_RST);
    run_phase(110, 1'b0, 1'b0);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0 && cfg_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sgbe_pkg.sv
design/stillness_gyro_bias_estimator_unit.sv
sim/tb.sv
